>>> hdl/nqsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nqsc_pkg
// Shared widths and the per-cell control bundle of the n-queens counter.
// ----------------------------------------------------------------------------
package nqsc_pkg;

    localparam int CFG_W = 5;   // board size register
    localparam int COL_W = 4;   // first column field

    // control that the sequencer hands to one row cell
    typedef struct packed {
        logic load;   // take the child masks offered by the upper neighbor
        logic take;   // consume the lowest free column of this row
    } nqsc_cell_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/nqsc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nqsc_cell
// One board row: holds the column, diagonal and free-column masks of its row
// and offers the masks of the row below to its neighbor every cycle.
// ----------------------------------------------------------------------------
module nqsc_cell #(
    parameter int BOARD = 16
) (
    input  wire logic                      aclk,
    input  wire nqsc_pkg::nqsc_cell_ctrl_t ctrl,
    input  wire logic [BOARD-1:0]          full_mask,
    input  wire logic [BOARD-1:0]          colm_in,
    input  wire logic [BOARD-1:0]          left_in,
    input  wire logic [BOARD-1:0]          right_in,
    input  wire logic [BOARD-1:0]          avail_in,
    output logic      [BOARD-1:0]          colm_out,
    output logic      [BOARD-1:0]          left_out,
    output logic      [BOARD-1:0]          right_out,
    output logic      [BOARD-1:0]          avail_out,
    output logic                           empty
);
    import nqsc_pkg::*;

    logic [BOARD-1:0] colm_reg,  colm_next;
    logic [BOARD-1:0] left_reg,  left_next;
    logic [BOARD-1:0] right_reg, right_next;
    logic [BOARD-1:0] avail_reg, avail_next;
    logic [BOARD-1:0] pick;

    // lowest free column
    assign pick  = avail_reg & (~avail_reg + BOARD'(1));
    assign empty = (avail_reg == '0);

    always_comb begin
        colm_out  = colm_reg | pick;
        left_out  = ((left_reg | pick) << 1) & full_mask;
        right_out = (right_reg | pick) >> 1;
        avail_out = full_mask & ~(colm_out | left_out | right_out);
    end

    always_comb begin
        colm_next  = colm_reg;
        left_next  = left_reg;
        right_next = right_reg;
        avail_next = avail_reg;
        if (ctrl.load) begin
            colm_next  = colm_in;
            left_next  = left_in;
            right_next = right_in;
            avail_next = avail_in;
        end else if (ctrl.take) begin
            avail_next = avail_reg ^ pick;
        end
    end

    always_ff @(posedge aclk) begin
        colm_reg  <= colm_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        avail_reg <= avail_next;
    end

endmodule
`default_nettype wire

>>> hdl/n_queens_solution_counter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// n_queens_solution_counter_unit
// Counts the n-queens placements that complete a fixed queen in row zero.
// ----------------------------------------------------------------------------
// Each transaction on s_ fixes the row-zero queen at s_first_column on a board
// of board_size rows (set by cfg_wr_en/cfg_wr_data, reset 8, clipped to
// MAX_BOARD) and returns one transaction on m_ with the number of complete
// placements, saturating at 2^COUNT_BITS-1. A column not below the board size
// returns count 0 with m_column_invalid set, without a search, by way of the
// done state. The search runs on a chain of MAX_BOARD row cells driven by one
// row pointer: every cycle does exactly one backtracking step, either trying
// the next free column of the current row or stepping back one row. One item
// is searched at a time; a new item is taken as soon as the previous result
// sits in the output register.
module n_queens_solution_counter_unit #(
    parameter int MAX_BOARD  = 16,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [nqsc_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [nqsc_pkg::COL_W-1:0]  s_first_column,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [COUNT_BITS-1:0]       m_solution_count,
    output logic                             m_column_invalid
);
    import nqsc_pkg::*;

    localparam int RW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam logic [CFG_W-1:0] SIZE_MAX   = CFG_W'(MAX_BOARD);
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      size_reg, size_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  invalid_reg, invalid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0] m_count_reg, m_count_next;
    logic                  m_invalid_reg, m_invalid_next;

    logic [CFG_W-1:0]      n_eff;
    logic [MAX_BOARD-1:0]  full_mask;
    logic [MAX_BOARD-1:0]  seed_avail;
    logic                  col_invalid;
    logic                  accept;
    logic                  start;
    logic                  cur_empty;
    logic                  at_last;
    logic                  step_take;
    logic                  step_descend;
    logic [MAX_BOARD-1:0]  empty_vec;
    logic [MAX_BOARD-1:0]  load_vec;

    nqsc_cell_ctrl_t       ctrl [MAX_BOARD];
    logic [MAX_BOARD-1:0]  colm_chain  [MAX_BOARD];
    logic [MAX_BOARD-1:0]  left_chain  [MAX_BOARD];
    logic [MAX_BOARD-1:0]  right_chain [MAX_BOARD];
    logic [MAX_BOARD-1:0]  avail_chain [MAX_BOARD];

    assign n_eff = (size_reg > SIZE_MAX) ? SIZE_MAX : size_reg;

    always_comb begin
        for (int i = 0; i < MAX_BOARD; i++) begin
            full_mask[i] = (CFG_W'(i) < n_eff);
        end
    end

    assign col_invalid = (CFG_W'(s_first_column) >= n_eff);
    assign seed_avail  = MAX_BOARD'(1) << s_first_column;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign start   = accept && !col_invalid;

    // row zero starts from empty masks with only the fixed column free
    assign colm_chain[0]  = '0;
    assign left_chain[0]  = '0;
    assign right_chain[0] = '0;
    assign avail_chain[0] = seed_avail;

    assign cur_empty    = empty_vec[row_reg];
    assign at_last      = (CFG_W'(row_reg) == n_eff - CFG_W'(1));
    assign step_take    = (state_reg == ST_SEARCH) && !cur_empty;
    assign step_descend = step_take && !at_last;

    always_comb begin
        for (int i = 0; i < MAX_BOARD; i++) begin
            ctrl[i].take = step_take && (row_reg == RW'(i));
            if (i == 0) begin
                ctrl[i].load = start;
            end else begin
                ctrl[i].load = step_descend && (row_reg == RW'(i - 1));
            end
            load_vec[i] = ctrl[i].load;
        end
    end

    for (genvar g = 0; g < MAX_BOARD; g++) begin : g_cell
        if (g < MAX_BOARD - 1) begin : g_link
            nqsc_cell #(
                .BOARD(MAX_BOARD)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[g]),
                .full_mask (full_mask),
                .colm_in   (colm_chain[g]),
                .left_in   (left_chain[g]),
                .right_in  (right_chain[g]),
                .avail_in  (avail_chain[g]),
                .colm_out  (colm_chain[g+1]),
                .left_out  (left_chain[g+1]),
                .right_out (right_chain[g+1]),
                .avail_out (avail_chain[g+1]),
                .empty     (empty_vec[g])
            );
        end else begin : g_tail
            // bottom row never descends, its child masks go nowhere
            nqsc_cell #(
                .BOARD(MAX_BOARD)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[g]),
                .full_mask (full_mask),
                .colm_in   (colm_chain[g]),
                .left_in   (left_chain[g]),
                .right_in  (right_chain[g]),
                .avail_in  (avail_chain[g]),
                .colm_out  (),
                .left_out  (),
                .right_out (),
                .avail_out (),
                .empty     (empty_vec[g])
            );
        end
    end

    always_comb begin
        state_next     = state_reg;
        size_next      = cfg_wr_en ? cfg_wr_data : size_reg;
        row_next       = row_reg;
        count_next     = count_reg;
        invalid_next   = invalid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_count_next   = m_count_reg;
        m_invalid_next = m_invalid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    invalid_next = col_invalid;
                    count_next   = '0;
                    row_next     = '0;
                    state_next   = col_invalid ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cur_empty) begin
                    if (row_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        row_next = row_reg - RW'(1);
                    end
                end else if (at_last) begin
                    if (count_reg != '1) begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_count_next   = count_reg;
                    m_invalid_next = invalid_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_RESET;
            row_reg     <= '0;
            count_reg   <= '0;
            invalid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            row_reg     <= row_next;
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
            m_valid_reg <= m_valid_next;
        end
        m_count_reg   <= m_count_next;
        m_invalid_reg <= m_invalid_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_solution_count = m_count_reg;
    assign m_column_invalid = m_invalid_reg;

    // a new result only comes out of the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid_reg && !m_ready)) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished search");

    // an out-of-board column never carries a count
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_column_invalid) |-> (m_solution_count == '0))
        else $error("invalid column result with nonzero count");

    // the row pointer stays on the board while searching
    a_row_on_board: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (CFG_W'(row_reg) < n_eff))
        else $error("row pointer beyond board size");

    // at most one cell loads per cycle
    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_vec))
        else $error("more than one row cell loaded");

endmodule
`default_nettype wire

>>> tb/sv/tb_n_queens_solution_counter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_n_queens_solution_counter_unit
// Self-checking bench for the n-queens completion counter.
// ----------------------------------------------------------------------------
// A scoreboard class predicts each count with its own bitmask backtracking
// search. It queues one expected result per accepted first column and checks
// each returned transaction against the oldest entry. Directed items cover
// the edge columns and small, empty and large boards. Random phases follow,
// each at its own board size. The sender runs in bursts with gaps, and the
// receiver stalls in changing patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_n_queens_solution_counter_unit;

    localparam int MAX_BOARD     = 16;
    localparam int COUNT_BITS    = 24;
    localparam int IDLE_LIMIT    = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 12;

    typedef struct {
        logic [COUNT_BITS-1:0] count;
        logic                  invalid;
    } queens_result_t;

    class queens_scoreboard;
        int unsigned    board_reg;
        queens_result_t pending_q[$];
        int unsigned    errors;

        function new();
            board_reg = 8;
            errors    = 0;
        endfunction

        function void set_board(int unsigned value);
            board_reg = value;
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction

        // depth-first walk over free-column masks, rows 1 .. rows-1
        function logic [COUNT_BITS-1:0] count_completions(int unsigned rows,
                                                          int unsigned first);
            int unsigned     colm[MAX_BOARD+1];
            int unsigned     lft[MAX_BOARD+1];
            int unsigned     rgt[MAX_BOARD+1];
            int unsigned     avl[MAX_BOARD+1];
            int unsigned     full;
            int unsigned     qb;
            int unsigned     lsb;
            int unsigned     r;
            longint unsigned cap;
            longint unsigned total;
            cap   = (64'd1 << COUNT_BITS) - 1;
            total = 0;
            if (rows == 1) begin
                return 1;
            end
            full    = (32'd1 << rows) - 1;
            qb      = 32'd1 << first;
            colm[1] = qb;
            lft[1]  = (qb << 1) & full;
            rgt[1]  = qb >> 1;
            avl[1]  = full & ~(colm[1] | lft[1] | rgt[1]);
            r       = 1;
            while (r >= 1) begin
                if (avl[r] == 0) begin
                    r--;
                end else begin
                    lsb    = avl[r] & (~avl[r] + 1);
                    avl[r] = avl[r] ^ lsb;
                    if (r == rows - 1) begin
                        if (total < cap) begin
                            total++;
                        end
                    end else begin
                        colm[r+1] = colm[r] | lsb;
                        lft[r+1]  = ((lft[r] | lsb) << 1) & full;
                        rgt[r+1]  = (rgt[r] | lsb) >> 1;
                        avl[r+1]  = full & ~(colm[r+1] | lft[r+1] | rgt[r+1]);
                        r++;
                    end
                end
            end
            return total[COUNT_BITS-1:0];
        endfunction

        function void note_accept(logic [nqsc_pkg::COL_W-1:0] first);
            queens_result_t exp_res;
            int unsigned    rows;
            rows = (board_reg > MAX_BOARD) ? MAX_BOARD : board_reg;
            if (first >= rows) begin
                exp_res.count   = '0;
                exp_res.invalid = 1'b1;
            end else begin
                exp_res.count   = count_completions(rows, first);
                exp_res.invalid = 1'b0;
            end
            pending_q.push_back(exp_res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [COUNT_BITS-1:0] count, logic invalid);
            queens_result_t exp_res;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result count=%0d invalid=%0b", count, invalid));
            end else begin
                exp_res = pending_q.pop_front();
                if (count !== exp_res.count) begin
                    report($sformatf("solution_count got %0d exp %0d",
                                     count, exp_res.count));
                end
                if (invalid !== exp_res.invalid) begin
                    report($sformatf("column_invalid got %0b exp %0b",
                                     invalid, exp_res.invalid));
                end
            end
        endtask
    endclass

    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        cfg_wr_en      = 1'b0;
    logic [nqsc_pkg::CFG_W-1:0]  cfg_wr_data    = '0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic [nqsc_pkg::COL_W-1:0]  s_first_column = '0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic [COUNT_BITS-1:0]       m_solution_count;
    logic                        m_column_invalid;

    queens_scoreboard sb;
    bit               hold_req   = 1'b0;
    int unsigned      burst_left = 0;

    n_queens_solution_counter_unit #(
        .MAX_BOARD  (MAX_BOARD),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_column   (s_first_column),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_solution_count (m_solution_count),
        .m_column_invalid (m_column_invalid)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one column and hold it until the transaction goes through
    task automatic send_item(input logic [nqsc_pkg::COL_W-1:0] col);
        s_valid        <= 1'b1;
        s_first_column <= col;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_accept(col);
    endtask

    task automatic pause(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // bursts of random length, some long ones without any gap
    task automatic next_slot();
        if (burst_left == 0) begin
            pause($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic set_board_size(input logic [nqsc_pkg::CFG_W-1:0] value);
        pause(1);
        while (sb.outstanding() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.set_board(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: checks results and stalls on a pattern that changes over time
    initial begin : result_side
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        bit          ready_next;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_solution_count, m_column_invalid);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = HOLD_CYCLES;
                ready_next = 1'b0;
            end else if (mode == 0) begin
                ready_next = 1'b1;
            end else if (mode == 1) begin
                ready_next = 1'($urandom_range(0, 1));
            end else begin
                ready_next = ($urandom_range(0, 7) == 0);
            end
            m_ready <= ready_next;
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("n_queens_solution_counter_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned rows;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset board of eight: edge columns on both sides of the boundary
        send_item(0);
        send_item(7);
        send_item(8);
        send_item(15);

        // empty board: every column invalid
        set_board_size(0);
        send_item(0);
        send_item(15);

        // single square: the fixed queen alone completes the board
        set_board_size(1);
        send_item(0);
        send_item(1);

        // boards with no completion at all
        set_board_size(2);
        send_item(0);
        send_item(1);
        set_board_size(3);
        send_item(0);
        send_item(1);
        send_item(2);

        set_board_size(12);
        send_item(0);
        send_item(12);

        // sizes at and above the clip point; a 16-row search runs too long
        // for this bench, so these are register writes only
        set_board_size(31);
        set_board_size(16);

        // long receiver hold-off while the sender keeps offering
        set_board_size(6);
        hold_req = 1'b1;
        repeat (8) send_item(nqsc_pkg::COL_W'($urandom_range(0, 15)));

        repeat (RANDOM_PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                rows = 0;
            end else if (pick < 10) begin
                rows = 1;
            end else if (pick < 15) begin
                rows = $urandom_range(2, 3);
            end else if (pick < 85) begin
                rows = $urandom_range(4, 9);
            end else if (pick < 97) begin
                rows = 10;
            end else begin
                rows = 11;
            end
            set_board_size(nqsc_pkg::CFG_W'(rows));
            burst_left = 0;
            repeat (PHASE_ITEMS) begin
                if (rows > 0 && $urandom_range(0, 3) != 0) begin
                    send_item(nqsc_pkg::COL_W'($urandom_range(0, rows - 1)));
                end else begin
                    send_item(nqsc_pkg::COL_W'($urandom_range(0, 15)));
                end
                next_slot();
            end
        end

        pause(1);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("n_queens_solution_counter_unit regression: pass");
        end else begin
            $display("n_queens_solution_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
